// ===== hdl/bcm_pkg.sv =====
// Shared types, constants and helpers for the binary cross morphology core.
`default_nettype none

package bcm_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int SIZE_W     = 11;
    localparam int ROW_W      = SIZE_W;
    localparam int POS_W      = SIZE_W + 2;
    localparam int LAT_W      = SIZE_W + 1;
    localparam int GREY_W     = 8;
    localparam int LEVEL_W    = 8;
    localparam int REG_COUNT  = 4;
    localparam int ADDR_W     = $clog2(REG_COUNT * 4);
    localparam int DATA_W     = 32;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [SIZE_W-1:0]  WIDTH_RESET  = SIZE_W'(640);
    localparam logic [SIZE_W-1:0]  HEIGHT_RESET = SIZE_W'(480);
    localparam logic [LEVEL_W-1:0] LEVEL_RESET  = LEVEL_W'(60);
    localparam logic [SIZE_W-1:0]  SIZE_MIN     = SIZE_W'(3);

    typedef enum logic [1:0] {
        MODE_DILATE,
        MODE_ERODE,
        MODE_OPEN,
        MODE_CLOSE
    } mode_t;

    typedef enum logic {
        MORPH_DILATE,
        MORPH_ERODE
    } morph_t;

    typedef enum logic [1:0] {
        REG_FRAME_WIDTH,
        REG_FRAME_HEIGHT,
        REG_OP_MODE,
        REG_BINARIZE_LEVEL
    } reg_idx_t;

    typedef enum logic {
        ACT_PIXEL,
        ACT_FLUSH
    } action_t;

    typedef struct packed {
        logic [SIZE_W-1:0]  width;
        logic [SIZE_W-1:0]  height;
        mode_t              mode;
        logic [LEVEL_W-1:0] level;
    } cfg_t;

    // One unit of work for the back end: a binarized pixel or a drain step
    typedef struct packed {
        logic pix;
        logic start;
        logic emit;
        logic last;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } tok_t;

    function automatic logic [SIZE_W-1:0] clamp_width(input logic [SIZE_W-1:0] w);
        logic [SIZE_W-1:0] r;
        r = w;
        if (w < SIZE_MIN)
            r = SIZE_MIN;
        else if (w > SIZE_W'(MAX_WIDTH))
            r = SIZE_W'(MAX_WIDTH);
        return r;
    endfunction

    function automatic logic [SIZE_W-1:0] clamp_height(input logic [SIZE_W-1:0] h);
        logic [SIZE_W-1:0] r;
        r = h;
        if (h < SIZE_MIN)
            r = SIZE_MIN;
        return r;
    endfunction

    function automatic logic is_two_stage(input mode_t m);
        return (m == MODE_OPEN) || (m == MODE_CLOSE);
    endfunction

endpackage

`default_nettype wire

// ===== hdl/bcm_in_if.sv =====
// Input pixel channel: valid/ready handshake with action and grey value.
`default_nettype none

interface bcm_in_if import bcm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              action;
    logic [GREY_W-1:0] grey_in;

    modport source (output valid, output action, output grey_in, input ready);
    modport sink (input valid, input action, input grey_in, output ready);
endinterface

`default_nettype wire

// ===== hdl/bcm_out_if.sv =====
// Result channel: valid/ready handshake with result pixel and end-of-frame mark.
`default_nettype none

interface bcm_out_if ();
    logic valid;
    logic ready;
    logic fg_out;
    logic frame_last;

    modport source (output valid, output fg_out, output frame_last, input ready);
    modport sink (input valid, input fg_out, input frame_last, output ready);
endinterface

`default_nettype wire

// ===== hdl/bcm_front.sv =====
// Front end: accepts items, binarizes pixels, tracks frame position and drain count.
`default_nettype none

module bcm_front import bcm_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    bcm_in_if.sink    pix_in,
    input  wire cfg_t cfg,
    input  wire logic restart,
    input  wire logic q_full,
    output logic      q_push,
    output cmd_t      q_cmd
);

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             done_reg, done_next;
    logic [LAT_W-1:0] drain_reg, drain_next;

    logic [SIZE_W-1:0] w;
    logic [SIZE_W-1:0] h;
    logic              two_stage;
    logic [LAT_W-1:0]  lat;
    logic              accept;
    logic              is_pixel;
    logic [COL_W-1:0]  cur_col;
    logic [ROW_W-1:0]  cur_row;
    logic              col_last;
    logic              row_last;
    logic              past_lat;
    logic              flush_emit;

    always_comb
    begin
        w         = clamp_width(cfg.width);
        h         = clamp_height(cfg.height);
        two_stage = is_two_stage(cfg.mode);
        lat       = two_stage ? (LAT_W'({w, 1'b0}) + LAT_W'(2)) : (LAT_W'(w) + LAT_W'(1));

        pix_in.ready = !q_full;
        accept       = pix_in.valid && pix_in.ready;
        is_pixel     = (action_t'(pix_in.action) == ACT_PIXEL);

        // a pixel after a complete frame opens a new one
        cur_col  = done_reg ? '0 : col_reg;
        cur_row  = done_reg ? '0 : row_reg;
        col_last = ({1'b0, cur_col} == (w - SIZE_W'(1)));
        row_last = (cur_row == (h - SIZE_W'(1)));

        // position at or beyond the latency of the selected mode
        if (two_stage)
            past_lat = (cur_row >= ROW_W'(3)) ||
                       ((cur_row == ROW_W'(2)) && (cur_col >= COL_W'(2)));
        else
            past_lat = (cur_row >= ROW_W'(2)) ||
                       ((cur_row == ROW_W'(1)) && (cur_col >= COL_W'(1)));

        flush_emit = done_reg && (drain_reg != '0);

        q_push      = accept && (is_pixel || flush_emit);
        q_cmd.pix   = is_pixel && (pix_in.grey_in > cfg.level);
        q_cmd.start = is_pixel && (cur_col == '0) && (cur_row == '0);
        q_cmd.emit  = is_pixel ? past_lat : 1'b1;
        q_cmd.last  = !is_pixel && (drain_reg == LAT_W'(1));

        col_next   = col_reg;
        row_next   = row_reg;
        done_next  = done_reg;
        drain_next = drain_reg;
        if (restart)
        begin
            col_next  = '0;
            row_next  = '0;
            done_next = 1'b0;
        end
        else if (accept)
        begin
            if (is_pixel)
            begin
                done_next = 1'b0;
                if (col_last && row_last)
                begin
                    col_next   = '0;
                    row_next   = '0;
                    done_next  = 1'b1;
                    drain_next = lat;
                end
                else if (col_last)
                begin
                    col_next = '0;
                    row_next = cur_row + ROW_W'(1);
                end
                else
                begin
                    col_next = cur_col + COL_W'(1);
                    row_next = cur_row;
                end
            end
            else if (flush_emit)
            begin
                drain_next = drain_reg - LAT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            done_reg  <= 1'b0;
            drain_reg <= '0;
        end
        else
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            done_reg  <= done_next;
            drain_reg <= drain_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/bcm_fifo.sv =====
// Short command queue between the front end and the back end.
`default_nettype none

module bcm_fifo import bcm_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    output logic      full,
    input  wire logic pop,
    output logic      nonempty,
    output cmd_t      head
);

    cmd_t               slot_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]   count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    always_comb
    begin
        full     = (count_reg == (FIFO_AW + 1)'(FIFO_DEPTH));
        nonempty = (count_reg != '0);
        head     = slot_reg[rd_ptr_reg];
        do_push  = push && !full;
        do_pop   = pop && nonempty;

        wr_ptr_next = do_push ? (wr_ptr_reg + FIFO_AW'(1)) : wr_ptr_reg;
        rd_ptr_next = do_pop ? (rd_ptr_reg + FIFO_AW'(1)) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + (FIFO_AW + 1)'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - (FIFO_AW + 1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

`default_nettype wire

// ===== hdl/bcm_stage.sv =====
// One cross morphology stage: two-row line buffer, 3x3 window and dilate/erode cell.
`default_nettype none

module bcm_stage import bcm_pkg::*; (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    en,
    input  wire tok_t                    in_tok,
    input  wire morph_t                  op,
    input  wire logic [SIZE_W-1:0]       width,
    input  wire logic [SIZE_W-1:0]       height,
    input  wire logic signed [POS_W-1:0] init_row,
    input  wire logic [COL_W-1:0]        init_col,
    output tok_t                         out_tok
);

    // line word: [1] pixel one row above, [0] pixel two rows above
    logic [1:0]       line_mem [MAX_WIDTH];
    logic [1:0]       rd_reg;

    logic [COL_W-1:0] col_reg, col_next;
    logic [COL_W-1:0] addr;

    tok_t             s1_reg;
    logic [COL_W-1:0] s1_col_reg;

    // window columns, newest first; each holds {top, mid, cur}
    logic [2:0]              win_reg [3];
    tok_t                    s2_reg;
    logic signed [POS_W-1:0] crow_reg;
    logic [COL_W-1:0]        ccol_reg;

    tok_t out_reg, out_next;

    logic                    shift;
    logic signed [POS_W-1:0] hs;
    logic signed [POS_W-1:0] ws;
    logic signed [POS_W-1:0] cs;
    logic ri_up, ri_mid, ri_dn;
    logic ci_left, ci_mid, ci_right;
    logic c_px, up_px, dn_px, lf_px, rt_px;
    logic result;

    always_comb
    begin
        addr     = in_tok.cmd.start ? '0 : col_reg;
        col_next = col_reg;
        if (en && in_tok.valid)
        begin
            if ({1'b0, addr} == (width - SIZE_W'(1)))
                col_next = '0;
            else
                col_next = addr + COL_W'(1);
        end
        shift = en && s1_reg.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            rd_reg <= line_mem[addr];
        if (shift)
            line_mem[s1_col_reg] <= {s1_reg.cmd.pix, rd_reg[1]};
    end

    always_ff @(posedge clk)
    begin
        if (en)
            s1_col_reg <= addr;
        if (shift)
        begin
            win_reg[2] <= win_reg[1];
            win_reg[1] <= win_reg[0];
            win_reg[0] <= {rd_reg[0], rd_reg[1], s1_reg.cmd.pix};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            s1_reg   <= '0;
            s2_reg   <= '0;
            out_reg  <= '0;
            crow_reg <= '0;
            ccol_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            if (en)
            begin
                s1_reg  <= in_tok;
                s2_reg  <= s1_reg;
                out_reg <= out_next;
            end
            if (shift)
            begin
                // center trails the incoming pixel by one row and one pixel
                if (s1_reg.cmd.start)
                begin
                    crow_reg <= init_row;
                    ccol_reg <= init_col;
                end
                else if ({1'b0, ccol_reg} == (width - SIZE_W'(1)))
                begin
                    crow_reg <= crow_reg + $signed(POS_W'(1));
                    ccol_reg <= '0;
                end
                else
                begin
                    ccol_reg <= ccol_reg + COL_W'(1);
                end
            end
        end
    end

    always_comb
    begin
        hs = $signed({2'b00, height});
        ws = $signed({2'b00, width});
        cs = $signed({{(POS_W - COL_W){1'b0}}, ccol_reg});

        ri_up  = (crow_reg >= $signed(POS_W'(2))) && (crow_reg <= hs - $signed(POS_W'(1)));
        ri_mid = (crow_reg >= $signed(POS_W'(1))) && (crow_reg <= hs - $signed(POS_W'(2)));
        ri_dn  = !crow_reg[POS_W-1] && (crow_reg <= hs - $signed(POS_W'(3)));

        ci_left  = (cs >= $signed(POS_W'(2)));
        ci_mid   = (cs >= $signed(POS_W'(1))) && (cs <= ws - $signed(POS_W'(2)));
        ci_right = (cs <= ws - $signed(POS_W'(3)));

        c_px  = win_reg[1][1];
        up_px = win_reg[1][2];
        dn_px = win_reg[1][0];
        lf_px = win_reg[2][1];
        rt_px = win_reg[0][1];

        case (op)
            MORPH_ERODE:
            begin
                if (ri_mid && ci_mid)
                    result = c_px & up_px & dn_px & lf_px & rt_px;
                else
                    result = c_px;
            end
            MORPH_DILATE:
            begin
                // only interior neighbors seed a dilation
                result = c_px
                       | (up_px & ri_up  & ci_mid)
                       | (dn_px & ri_dn  & ci_mid)
                       | (lf_px & ri_mid & ci_left)
                       | (rt_px & ri_mid & ci_right);
            end
            default:
            begin
                result = c_px;
            end
        endcase

        out_next         = s2_reg;
        out_next.cmd.pix = result;

        out_tok = out_reg;
    end

endmodule

`default_nettype wire

// ===== hdl/bcm_back.sv =====
// Back end: two cascaded morphology stages, mode select and the result register.
`default_nettype none

module bcm_back import bcm_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cfg_t cfg,
    input  wire logic q_nonempty,
    input  wire cmd_t q_head,
    output logic      q_pop,
    bcm_out_if.source pix_out
);

    logic out_valid_reg;
    logic fg_reg;
    logic last_reg;

    logic              en;
    tok_t              a_in;
    tok_t              a_out;
    tok_t              b_out;
    tok_t              sel;
    morph_t            op_a;
    morph_t            op_b;
    logic [SIZE_W-1:0] w;
    logic [SIZE_W-1:0] h;
    logic [COL_W-1:0]  init_col_a;
    logic [COL_W-1:0]  init_col_b;

    always_comb
    begin
        w  = clamp_width(cfg.width);
        h  = clamp_height(cfg.height);
        en = !out_valid_reg || pix_out.ready;

        q_pop      = en && q_nonempty;
        a_in.valid = q_nonempty;
        a_in.cmd   = q_head;

        op_a = ((cfg.mode == MODE_ERODE) || (cfg.mode == MODE_OPEN)) ? MORPH_ERODE : MORPH_DILATE;
        op_b = (cfg.mode == MODE_CLOSE) ? MORPH_ERODE : MORPH_DILATE;

        // first stage center starts W+1 pixels back, second stage 2W+2
        init_col_a = COL_W'(w - SIZE_W'(1));
        init_col_b = COL_W'(w - SIZE_W'(2));

        sel = is_two_stage(cfg.mode) ? b_out : a_out;

        pix_out.valid      = out_valid_reg;
        pix_out.fg_out     = fg_reg;
        pix_out.frame_last = last_reg;
    end

    bcm_stage u_stage_a (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_tok   (a_in),
        .op       (op_a),
        .width    (w),
        .height   (h),
        .init_row ($signed(POS_W'(-2))),
        .init_col (init_col_a),
        .out_tok  (a_out)
    );

    bcm_stage u_stage_b (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_tok   (a_out),
        .op       (op_b),
        .width    (w),
        .height   (h),
        .init_row ($signed(POS_W'(-3))),
        .init_col (init_col_b),
        .out_tok  (b_out)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= sel.valid && sel.cmd.emit;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fg_reg   <= sel.cmd.pix;
            last_reg <= sel.cmd.last;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/binary_cross_morphology_core.sv =====
// Top level of the binary cross morphology core: register file and front/back wiring.
//
// Usage: grey pixels enter in raster order on pix_in (action 0); each is binarized
// against binarize_level and run through a 4-neighbour cross dilate, erode, open or
// close selected by op_mode. Results leave on pix_out, one per transfer, with
// frame_last marking the final pixel of a frame. Results trail the input by W+1
// pixels (dilate, erode) or 2W+2 pixels (open, close); once the last pixel of a
// frame is in, each flush transfer (action 1) drains one pending result.
// Throughput is one item per cycle while pix_out does not stall. From the transfer
// that produces it, a result passes the command queue, the line buffer read, window
// and result registers of each stage in use, and the output register.
// Configuration is written over the APB port while the stream is idle; writing
// frame_width, frame_height or op_mode abandons the current frame.
// Reset loads the default geometry (640x480, dilate, level 60) and empties the
// command queue; no line buffer clearing is needed.
// When pix_out stalls the back end holds; the 4-entry command queue keeps
// accepting until full, then pix_in.ready drops.
`default_nettype none

module binary_cross_morphology_core import bcm_pkg::*; (
    input  wire logic              clk,
    input  wire logic              rst_n,
    bcm_in_if.sink                 pix_in,
    bcm_out_if.source              pix_out,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0]      prdata,
    output logic                   pready
);

    cfg_t     cfg_reg;
    logic     wr_en;
    reg_idx_t idx;
    logic     restart;

    logic q_push;
    cmd_t q_cmd;
    logic q_full;
    logic q_pop;
    logic q_nonempty;
    cmd_t q_head;

    always_comb
    begin
        pready  = 1'b1;
        idx     = reg_idx_t'(paddr[ADDR_W-1:2]);
        wr_en   = psel && penable && pwrite && pready;
        restart = wr_en && (idx != REG_BINARIZE_LEVEL);

        case (idx)
            REG_FRAME_WIDTH:    prdata = DATA_W'(cfg_reg.width);
            REG_FRAME_HEIGHT:   prdata = DATA_W'(cfg_reg.height);
            REG_OP_MODE:        prdata = DATA_W'(cfg_reg.mode);
            REG_BINARIZE_LEVEL: prdata = DATA_W'(cfg_reg.level);
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.width  <= WIDTH_RESET;
            cfg_reg.height <= HEIGHT_RESET;
            cfg_reg.mode   <= MODE_DILATE;
            cfg_reg.level  <= LEVEL_RESET;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_FRAME_WIDTH:    cfg_reg.width  <= pwdata[SIZE_W-1:0];
                REG_FRAME_HEIGHT:   cfg_reg.height <= pwdata[SIZE_W-1:0];
                REG_OP_MODE:        cfg_reg.mode   <= mode_t'(pwdata[1:0]);
                REG_BINARIZE_LEVEL: cfg_reg.level  <= pwdata[LEVEL_W-1:0];
                default:            cfg_reg        <= cfg_reg;
            endcase
        end
    end

    bcm_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix_in  (pix_in),
        .cfg     (cfg_reg),
        .restart (restart),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_cmd   (q_cmd)
    );

    bcm_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .nonempty (q_nonempty),
        .head     (q_head)
    );

    bcm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .q_nonempty (q_nonempty),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .pix_out    (pix_out)
    );

endmodule

`default_nettype wire

// ===== bench/morph_checker.sv =====
// Result checker for the cross morphology core: tracks register writes, predicts pixels, compares.
module morph_checker import bcm_pkg::*; (
    input  wire logic              clk,
    input  wire logic              rst_n,
    bcm_in_if                      pix_in,
    bcm_out_if                     pix_out,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    input  wire logic [DATA_W-1:0] prdata,
    input  wire logic              pready,
    output int                     mismatch_count,
    output int                     awaited_count
);

    typedef struct packed {
        logic fg;
        logic last;
    } pixel_result_t;

    pixel_result_t        pixel_q[$];
    logic [MAX_WIDTH-1:0] bin_rows [8];
    logic [SIZE_W-1:0]    width_reg;
    logic [SIZE_W-1:0]    height_reg;
    mode_t                mode_reg;
    logic [LEVEL_W-1:0]   level_reg;
    int                   pix_seen;
    int                   pix_done;
    int                   fail_tally;

    function automatic int span_w();
        int w;
        w = int'(width_reg);
        if (w < 3)
            w = 3;
        if (w > MAX_WIDTH)
            w = MAX_WIDTH;
        return w;
    endfunction

    function automatic int span_h();
        int h;
        h = int'(height_reg);
        if (h < 3)
            h = 3;
        return h;
    endfunction

    function automatic logic bin_at(input int r, input int c);
        return bin_rows[r & 7][c];
    endfunction

    function automatic bit is_core(input int r, input int c, input int w, input int h);
        return (r >= 1) && (r <= h - 2) && (c >= 1) && (c <= w - 2);
    endfunction

    // Border pixels never erode
    function automatic logic eroded(input int r, input int c, input int w, input int h);
        if (!is_core(r, c, w, h))
            return bin_at(r, c);
        return bin_at(r, c) & bin_at(r - 1, c) & bin_at(r + 1, c)
             & bin_at(r, c - 1) & bin_at(r, c + 1);
    endfunction

    function automatic logic seed(input bit from_ero, input int r, input int c,
                                  input int w, input int h);
        return from_ero ? eroded(r, c, w, h) : bin_at(r, c);
    endfunction

    // Only interior neighbours spread foreground
    function automatic logic dilated(input bit from_ero, input int r, input int c,
                                     input int w, input int h);
        logic v;
        v = seed(from_ero, r, c, w, h);
        if (is_core(r - 1, c, w, h))
            v = v | seed(from_ero, r - 1, c, w, h);
        if (is_core(r + 1, c, w, h))
            v = v | seed(from_ero, r + 1, c, w, h);
        if (is_core(r, c - 1, w, h))
            v = v | seed(from_ero, r, c - 1, w, h);
        if (is_core(r, c + 1, w, h))
            v = v | seed(from_ero, r, c + 1, w, h);
        return v;
    endfunction

    function automatic logic closed(input int r, input int c, input int w, input int h);
        if (!is_core(r, c, w, h))
            return dilated(1'b0, r, c, w, h);
        return dilated(1'b0, r, c, w, h) & dilated(1'b0, r - 1, c, w, h)
             & dilated(1'b0, r + 1, c, w, h) & dilated(1'b0, r, c - 1, w, h)
             & dilated(1'b0, r, c + 1, w, h);
    endfunction

    task automatic emit_next(input int w, input int h);
        int r;
        int c;
        pixel_result_t res;
        r = pix_done / w;
        c = pix_done % w;
        case (mode_reg)
            MODE_DILATE: res.fg = dilated(1'b0, r, c, w, h);
            MODE_ERODE:  res.fg = eroded(r, c, w, h);
            MODE_OPEN:   res.fg = dilated(1'b1, r, c, w, h);
            default:     res.fg = closed(r, c, w, h);
        endcase
        res.last = (pix_done + 1 == w * h);
        pixel_q.push_back(res);
        pix_done++;
    endtask

    task automatic predict_item(input logic act, input logic [GREY_W-1:0] grey);
        int w;
        int h;
        int n;
        int lat;
        int k;
        w = span_w();
        h = span_h();
        n = w * h;
        lat = (mode_reg == MODE_OPEN || mode_reg == MODE_CLOSE) ? 2 * w + 2 : w + 1;
        if (action_t'(act) == ACT_PIXEL) begin
            // a pixel after a complete frame opens the next one
            if (pix_seen >= n) begin
                pix_seen = 0;
                pix_done = 0;
            end
            k = pix_seen;
            bin_rows[(k / w) & 7][k % w] = (grey > level_reg);
            pix_seen = k + 1;
            if (k >= lat && pix_done < pix_seen)
                emit_next(w, h);
        end
        else if (pix_seen >= n && pix_done < n) begin
            emit_next(w, h);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin : watch
        reg_idx_t           idx;
        logic [DATA_W-1:0]  want;
        pixel_result_t      head;
        if (!rst_n) begin
            for (int i = 0; i < 8; i++)
                bin_rows[i] = '0;
            pixel_q.delete();
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            mode_reg   = MODE_DILATE;
            level_reg  = LEVEL_RESET;
            pix_seen   = 0;
            pix_done   = 0;
            fail_tally = 0;
            mismatch_count <= 0;
            awaited_count  <= 0;
        end
        else begin
            if (psel && penable && pready) begin
                idx = reg_idx_t'(paddr[ADDR_W-1:2]);
                if (pwrite) begin
                    case (idx)
                        REG_FRAME_WIDTH:  width_reg  = pwdata[SIZE_W-1:0];
                        REG_FRAME_HEIGHT: height_reg = pwdata[SIZE_W-1:0];
                        REG_OP_MODE:      mode_reg   = mode_t'(pwdata[1:0]);
                        default:          level_reg  = pwdata[LEVEL_W-1:0];
                    endcase
                    // geometry and mode writes abandon the frame
                    if (idx != REG_BINARIZE_LEVEL) begin
                        pix_seen = 0;
                        pix_done = 0;
                    end
                end
                else begin
                    case (idx)
                        REG_FRAME_WIDTH:  want = DATA_W'(width_reg);
                        REG_FRAME_HEIGHT: want = DATA_W'(height_reg);
                        REG_OP_MODE:      want = DATA_W'(mode_reg);
                        default:          want = DATA_W'(level_reg);
                    endcase
                    if (prdata !== want) begin
                        $display("%0t: read of %s expected %h got %h",
                                 $time, idx.name(), want, prdata);
                        fail_tally++;
                    end
                end
            end

            if (pix_out.valid && pix_out.ready) begin
                if (pixel_q.size() == 0) begin
                    $display("%0t: result transfer expected none got fg_out=%0b frame_last=%0b",
                             $time, pix_out.fg_out, pix_out.frame_last);
                    fail_tally++;
                end
                else begin
                    head = pixel_q.pop_front();
                    if (pix_out.fg_out !== head.fg) begin
                        $display("%0t: fg_out expected %0b got %0b",
                                 $time, head.fg, pix_out.fg_out);
                        fail_tally++;
                    end
                    if (pix_out.frame_last !== head.last) begin
                        $display("%0t: frame_last expected %0b got %0b",
                                 $time, head.last, pix_out.frame_last);
                        fail_tally++;
                    end
                end
            end

            if (pix_in.valid && pix_in.ready)
                predict_item(pix_in.action, pix_in.grey_in);

            mismatch_count <= fail_tally;
            awaited_count  <= pixel_q.size();
        end
    end

endmodule

// ===== bench/testbench.sv =====
// Stimulus and verdict for the cross morphology core: pixel frames, flushes and APB setup.
module testbench;
    import bcm_pkg::*;

    localparam int DRAIN_CYCLES = 24;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 4000;
    localparam int RANDOM_ITEMS = 750;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    int                mismatch_count;
    int                awaited_count;
    int                useful_items;
    bit                steady;
    bit                hold_request;

    bcm_in_if  pix_in_ch ();
    bcm_out_if pix_out_ch ();

    binary_cross_morphology_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix_in  (pix_in_ch),
        .pix_out (pix_out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    morph_checker result_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .pix_in         (pix_in_ch),
        .pix_out        (pix_out_ch),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .mismatch_count (mismatch_count),
        .awaited_count  (awaited_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int idle_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [GREY_W-1:0] grey_sample(input int lvl, input int dens);
        if ($urandom_range(0, 99) < 8)
            return GREY_W'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < dens)
        begin
            if (lvl >= 255)
                return 8'hFF;
            return GREY_W'($urandom_range(lvl + 1, 255));
        end
        return GREY_W'($urandom_range(0, lvl));
    endfunction

    task automatic offer(input action_t act, input logic [GREY_W-1:0] grey);
        int gap;
        gap = idle_gap();
        if (gap > 0)
        begin
            pix_in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_in_ch.valid   <= 1'b1;
        pix_in_ch.action  <= act;
        pix_in_ch.grey_in <= grey;
        @(posedge clk);
        while (!pix_in_ch.ready)
            @(posedge clk);
    endtask

    // Early flushes land mid-frame and must be ignored
    task automatic feed_pixels(input int count, input int dens, input int lvl);
        for (int i = 0; i < count; i++)
        begin
            if (!steady && $urandom_range(0, 49) == 0)
                offer(ACT_FLUSH, GREY_W'($urandom_range(0, 255)));
            offer(ACT_PIXEL, grey_sample(lvl, dens));
            useful_items++;
        end
    endtask

    task automatic drain(input int count);
        for (int i = 0; i < count; i++)
        begin
            offer(ACT_FLUSH, GREY_W'($urandom_range(0, 255)));
            useful_items++;
        end
    endtask

    // Drop valid, wait out every pending result, then let the pipeline empty
    task automatic settle();
        pix_in_ch.valid <= 1'b0;
        @(posedge clk);
        while (awaited_count != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apb_access(input reg_idx_t idx, input logic wr, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input int w, input int h, input mode_t m, input int lvl);
        settle();
        apb_access(REG_FRAME_WIDTH, 1'b1, DATA_W'(w));
        apb_access(REG_FRAME_HEIGHT, 1'b1, DATA_W'(h));
        apb_access(REG_OP_MODE, 1'b1, DATA_W'(m));
        apb_access(REG_BINARIZE_LEVEL, 1'b1, DATA_W'(lvl));
        apb_access(REG_FRAME_WIDTH, 1'b0, '0);
        apb_access(REG_FRAME_HEIGHT, 1'b0, '0);
        apb_access(REG_OP_MODE, 1'b0, '0);
        apb_access(REG_BINARIZE_LEVEL, 1'b0, '0);
    endtask

    initial
    begin : result_sink
        int r;
        int span;
        pix_out_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_request)
            begin
                // hold off long enough for the input side to back up
                hold_request = 1'b0;
                pix_out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            r = $urandom_range(0, 99);
            if (steady || r < 60)
            begin
                pix_out_ch.ready <= 1'b1;
                span = steady ? 1 : $urandom_range(1, 20);
            end
            else if (r < 94)
            begin
                pix_out_ch.ready <= 1'b0;
                span = $urandom_range(1, 3);
            end
            else
            begin
                pix_out_ch.ready <= 1'b0;
                span = $urandom_range(10, 50);
            end
            repeat (span) @(posedge clk);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((pix_in_ch.valid && pix_in_ch.ready) || (pix_out_ch.valid && pix_out_ch.ready)
                || psel)
                quiet = 0;
            else
                quiet++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin : stimulus
        logic [GREY_W-1:0] sparse_frame [9];
        logic [GREY_W-1:0] cross_frame [9];
        mode_t m;
        int    w;
        int    h;
        int    we;
        int    he;
        int    n;
        int    lat;
        int    lvl;
        int    pick;
        int    frames;
        int    dens;
        int    start;

        sparse_frame = '{8'd0, 8'd255, 8'd0, 8'd0, 8'd1, 8'd0, 8'd0, 8'd0, 8'd255};
        cross_frame  = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0};
        useful_items = 0;
        steady       = 1'b0;
        hold_request = 1'b0;
        rst_n   <= 1'b0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        pix_in_ch.valid   <= 1'b0;
        pix_in_ch.action  <= ACT_PIXEL;
        pix_in_ch.grey_in <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Smallest frame at the lowest level, early flush, partial drain
        configure(3, 3, MODE_DILATE, 0);
        for (int i = 0; i < 9; i++)
        begin
            if (i == 4)
                offer(ACT_FLUSH, 8'hFF);
            offer(ACT_PIXEL, sparse_frame[i]);
        end
        drain(2);
        // Next frame starts over the undrained results; extra flush is ignored
        for (int i = 0; i < 9; i++)
            offer(ACT_PIXEL, cross_frame[i]);
        drain(4);
        offer(ACT_FLUSH, 8'h00);

        // Long receiver hold-off while pixels keep coming
        configure(10, 6, MODE_OPEN, 100);
        hold_request = 1'b1;
        feed_pixels(60, 50, 100);
        drain(22);

        // Widest rows: width clamped from the top of its range, dropped by the next write
        lvl = $urandom_range(0, 255);
        configure(2047, 2047, MODE_CLOSE, lvl);
        feed_pixels(40, 60, lvl);

        start = useful_items;
        while (useful_items - start < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
                w = $urandom_range(0, 2);
            else if (pick < 90)
                w = $urandom_range(3, 12);
            else
                w = $urandom_range(13, 40);
            pick = $urandom_range(0, 99);
            h = (pick < 8) ? $urandom_range(0, 2) : $urandom_range(3, 8);
            m = mode_t'($urandom_range(0, 3));
            pick = $urandom_range(0, 99);
            if (pick < 10)
                lvl = 0;
            else if (pick < 20)
                lvl = 255;
            else
                lvl = $urandom_range(0, 255);
            configure(w, h, m, lvl);
            steady = ($urandom_range(0, 5) == 0);
            we = (w < 3) ? 3 : w;
            he = (h < 3) ? 3 : h;
            n = we * he;
            lat = (m == MODE_OPEN || m == MODE_CLOSE) ? 2 * we + 2 : we + 1;
            frames = $urandom_range(1, 3);
            for (int f = 0; f < frames; f++)
            begin
                dens = $urandom_range(15, 90);
                pick = $urandom_range(0, 99);
                if (pick < 10)
                begin
                    // partial frame, abandoned by the next register write
                    feed_pixels($urandom_range(1, n - 1), dens, lvl);
                    break;
                end
                feed_pixels(n, dens, lvl);
                if (pick < 80)
                begin
                    drain(lat);
                end
                else if (pick < 90)
                begin
                    drain(lat);
                    repeat ($urandom_range(1, 3))
                        offer(ACT_FLUSH, GREY_W'($urandom_range(0, 255)));
                end
                else
                begin
                    drain($urandom_range(0, lat - 1));
                end
            end
            steady = 1'b0;
        end

        settle();
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/bcm_pkg.sv
hdl/bcm_in_if.sv
hdl/bcm_out_if.sv
hdl/bcm_front.sv
hdl/bcm_fifo.sv
hdl/bcm_stage.sv
hdl/bcm_back.sv
hdl/binary_cross_morphology_core.sv
bench/morph_checker.sv
bench/testbench.sv
